// ----- hdl/hbh_pkg.sv -----
`default_nettype none

package hbh_pkg;

  // Command codes carried on the cmd port.
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_CLEAR  = 2'd1;
  localparam logic [1:0] CMD_REPORT = 2'd2;

  localparam int CMD_W = 2;
  localparam int HASH_W = 64;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W = 17;
  localparam logic [CFG_INDEX_W-1:0] REG_BUCKET_COUNT = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_USE_MASK     = 1'b1;
  localparam logic [CFG_DATA_W-1:0] BUCKET_COUNT_RESET = 17'd1024;

  // Result field widths.
  localparam int TOTAL_W = 40;
  localparam int BUCKET_OUT_W = 32;
  localparam int EMPTY_W = 17;
  localparam int MEAN_W = 56;
  localparam int CHI_W = 48;
  localparam int FRAC_W = 16;

endpackage

`default_nettype wire

// ----- hdl/hash_bucket_histogram_stats_core.sv -----
`default_nettype none

// Hash bucket histogram with distribution statistics.
// Commands enter on start/cmd/hash_key and are taken when start is high and
// busy is low. An add word reduces hash_key to a bucket index (mask or
// remainder, per use_mask), bumps that bucket, the entry total and the peak.
// A clear word zeroes the histogram. A report word scans the buckets in use
// and returns one result word, marked by done for exactly one cycle; the
// receiver cannot stall, so it must take the word in that cycle.
// Configuration is a plain write port (cfg_write, cfg_index, cfg_data). The
// user must write it only while the block is idle; it is not enforced.
// An add in mask mode reads the bucket and writes it back incremented; in
// remainder mode a one-bit-per-cycle divider first forms the remainder. A
// clear zeroes every memory row, one row per cycle. A report squares each
// bucket in use on the serial multiplier; then, unless the total is zero or
// one bucket is in use, four multiplies and a long division form chi-square,
// and a long division forms the mean. Multiplies, divides and the sum of
// counts share one add/subtract unit. After reset the block zeroes the bucket
// memory with busy high; configuration writes are still taken then.
module hash_bucket_histogram_stats_core #(
  parameter int MAX_BUCKETS = 65536,
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    start,
  output logic                                         busy,
  input  wire logic [hbh_pkg::CMD_W-1:0]               cmd,
  input  wire logic [hbh_pkg::HASH_W-1:0]              hash_key,
  input  wire logic                                    cfg_write,
  input  wire logic [hbh_pkg::CFG_INDEX_W-1:0]         cfg_index,
  input  wire logic [hbh_pkg::CFG_DATA_W-1:0]          cfg_data,
  output logic                                         done,
  output logic [hbh_pkg::TOTAL_W-1:0]                  total_entries,
  output logic [hbh_pkg::BUCKET_OUT_W-1:0]             largest_bucket,
  output logic [hbh_pkg::BUCKET_OUT_W-1:0]             smallest_bucket,
  output logic [hbh_pkg::EMPTY_W-1:0]                  empty_buckets,
  output logic [hbh_pkg::MEAN_W-1:0]                   mean_q16,
  output logic [hbh_pkg::CHI_W-1:0]                    chi_square_q16
);

  // Index and bucket-count widths.
  localparam int IDXW = $clog2(MAX_BUCKETS);
  localparam int NBW = IDXW + 1;
  localparam int CW = COUNT_WIDTH;
  localparam int TW = hbh_pkg::TOTAL_W;
  // Sum of counts over all buckets.
  localparam int UW = CW + IDXW;
  // The chi-square numerator n*S + T*T - 2*T*U fits in NW bits.
  localparam int NW_A = 2 * CW + 2 * IDXW + 1;
  localparam int NW = ((NW_A > 2 * TW) ? NW_A : 2 * TW) + 2;
  localparam int AW = NW;
  // Divider remainder: the divisor T*(n-1) stays below 2^(TW+IDXW).
  localparam int RW = TW + IDXW + 1;
  localparam int DVW = NW + hbh_pkg::FRAC_W;
  localparam int QW = hbh_pkg::MEAN_W;
  localparam int MW = (CW > TW) ? CW : TW;
  localparam int CNTW = $clog2(DVW + 1);
  localparam int CMPW = (NBW > hbh_pkg::CFG_DATA_W) ? NBW : hbh_pkg::CFG_DATA_W;

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_CLEAR    = 5'd1;
  localparam logic [4:0] S_ADD_IDX  = 5'd2;
  localparam logic [4:0] S_ADD_RD   = 5'd3;
  localparam logic [4:0] S_ADD_WR   = 5'd4;
  localparam logic [4:0] S_SCAN_RD  = 5'd5;
  localparam logic [4:0] S_SCAN_LD  = 5'd6;
  localparam logic [4:0] S_SCAN_NX  = 5'd7;
  localparam logic [4:0] S_MUL      = 5'd8;
  localparam logic [4:0] S_DIV      = 5'd9;
  localparam logic [4:0] S_POST_NS  = 5'd10;
  localparam logic [4:0] S_POST_TT  = 5'd11;
  localparam logic [4:0] S_POST_TU  = 5'd12;
  localparam logic [4:0] S_POST_D   = 5'd13;
  localparam logic [4:0] S_POST_DIV = 5'd14;
  localparam logic [4:0] S_POST_CHI = 5'd15;
  localparam logic [4:0] S_MEAN     = 5'd16;
  localparam logic [4:0] S_DONE     = 5'd17;

  // Sequencer state; ret is where a multiply or divide run returns to.
  logic [4:0] state;
  logic [4:0] ret;

  // Configuration registers.
  logic [hbh_pkg::CFG_DATA_W-1:0] bucket_count;
  logic                           use_mask;

  // Histogram summary state.
  logic [TW-1:0] total;
  logic [CW-1:0] peak;

  // Scan and add bookkeeping.
  logic [IDXW-1:0] scan_i;
  logic [IDXW-1:0] idx;
  logic [UW-1:0]   uacc;
  logic [CW-1:0]   lo;
  logic [NBW-1:0]  empty;

  // Shift-add multiplier registers.
  logic [AW-1:0]   acc;
  logic [AW-1:0]   mcand;
  logic [MW-1:0]   mplier;
  logic            mul_sub;

  // Restoring divider registers.
  logic [DVW-1:0]  dvd;
  logic [RW-1:0]   dreg;
  logic [RW-1:0]   rem;
  logic [QW-1:0]   q;
  logic            ovf;
  logic [CNTW-1:0] cnt;

  logic [hbh_pkg::CHI_W-1:0] chi_res;

  // Memory port.
  logic            ram_we;
  logic [IDXW-1:0] ram_addr;
  logic [CW-1:0]   ram_wdata;
  logic [CW-1:0]   ram_rdata;

  // Shared add/subtract unit; the top bit is the carry, which for a subtract
  // means the first operand is not below the second.
  logic [AW-1:0] add_a;
  logic [AW-1:0] add_b;
  logic          add_sub;
  logic [AW:0]   add_res;

  logic [NBW-1:0]  n_act;
  logic [NBW-1:0]  n_minus1;
  logic [RW-1:0]   trial;
  logic            ge;
  logic [CW-1:0]   c_inc;
  logic [IDXW-1:0] mask_idx;

  hbh_ram #(
    .DEPTH (MAX_BUCKETS),
    .WIDTH (CW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign busy = (state != S_IDLE);

  // Buckets in use: zero acts as one, anything above the built depth as the
  // full depth.
  always_comb begin
    if (bucket_count == '0) begin
      n_act = NBW'(1);
    end else if (CMPW'(bucket_count) > CMPW'(MAX_BUCKETS)) begin
      n_act = NBW'(MAX_BUCKETS);
    end else begin
      n_act = NBW'(bucket_count);
    end
  end

  assign n_minus1 = n_act - NBW'(1);
  assign mask_idx = hash_key[IDXW-1:0] & n_minus1[IDXW-1:0];
  assign c_inc = (ram_rdata == {CW{1'b1}}) ? ram_rdata : ram_rdata + CW'(1);

  // One division step: shift the next dividend bit into the remainder.
  assign trial = {rem[RW-2:0], dvd[DVW-1]};

  always_comb begin
    add_a = acc;
    add_b = mcand;
    add_sub = mul_sub;
    case (state)
      S_DIV: begin
        add_a = AW'(trial);
        add_b = AW'(dreg);
        add_sub = 1'b1;
      end
      S_SCAN_LD: begin
        add_a = AW'(uacc);
        add_b = AW'(ram_rdata);
        add_sub = 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign add_res = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)} + (AW + 1)'(add_sub);
  assign ge = add_res[AW];

  always_comb begin
    ram_we = 1'b0;
    ram_addr = scan_i;
    ram_wdata = c_inc;
    unique case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
        ram_wdata = '0;
      end
      S_ADD_RD: begin
        ram_addr = idx;
      end
      S_ADD_WR: begin
        ram_we = 1'b1;
        ram_addr = idx;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      scan_i <= '0;
      total <= '0;
      peak <= '0;
      bucket_count <= hbh_pkg::BUCKET_COUNT_RESET;
      use_mask <= 1'b1;
      done <= 1'b0;
    end else begin
      done <= 1'b0;

      if (cfg_write) begin
        unique case (cfg_index)
          hbh_pkg::REG_BUCKET_COUNT: bucket_count <= cfg_data;
          hbh_pkg::REG_USE_MASK:     use_mask <= cfg_data[0];
          default: begin
          end
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (start) begin
            case (cmd)
              hbh_pkg::CMD_ADD: begin
                if (use_mask) begin
                  idx <= mask_idx;
                  state <= S_ADD_RD;
                end else begin
                  dvd <= {hash_key, {(DVW - hbh_pkg::HASH_W){1'b0}}};
                  dreg <= RW'(n_act);
                  rem <= '0;
                  q <= '0;
                  ovf <= 1'b0;
                  cnt <= CNTW'(hbh_pkg::HASH_W);
                  ret <= S_ADD_IDX;
                  state <= S_DIV;
                end
              end
              hbh_pkg::CMD_CLEAR: begin
                scan_i <= '0;
                total <= '0;
                peak <= '0;
                state <= S_CLEAR;
              end
              hbh_pkg::CMD_REPORT: begin
                scan_i <= '0;
                acc <= '0;
                uacc <= '0;
                lo <= peak;
                empty <= '0;
                state <= S_SCAN_RD;
              end
              default: begin
              end
            endcase
          end
        end

        S_CLEAR: begin
          if (scan_i == IDXW'(MAX_BUCKETS - 1)) begin
            state <= S_IDLE;
          end else begin
            scan_i <= scan_i + IDXW'(1);
          end
        end

        S_ADD_IDX: begin
          idx <= rem[IDXW-1:0];
          state <= S_ADD_RD;
        end

        S_ADD_RD: begin
          state <= S_ADD_WR;
        end

        S_ADD_WR: begin
          if (c_inc > peak) begin
            peak <= c_inc;
          end
          if (total != {TW{1'b1}}) begin
            total <= total + TW'(1);
          end
          state <= S_IDLE;
        end

        S_SCAN_RD: begin
          state <= S_SCAN_LD;
        end

        S_SCAN_LD: begin
          uacc <= add_res[UW-1:0];
          if (ram_rdata < lo) begin
            lo <= ram_rdata;
          end
          if (ram_rdata == '0) begin
            empty <= empty + NBW'(1);
          end
          mcand <= AW'(ram_rdata);
          mplier <= MW'(ram_rdata);
          mul_sub <= 1'b0;
          cnt <= CNTW'(CW);
          ret <= S_SCAN_NX;
          state <= S_MUL;
        end

        S_SCAN_NX: begin
          if (NBW'(scan_i) == n_minus1) begin
            state <= S_POST_NS;
          end else begin
            scan_i <= scan_i + IDXW'(1);
            state <= S_SCAN_RD;
          end
        end

        S_MUL: begin
          if (mplier[0]) begin
            acc <= add_res[AW-1:0];
          end
          mcand <= mcand << 1;
          mplier <= mplier >> 1;
          cnt <= cnt - CNTW'(1);
          if (cnt == CNTW'(1)) begin
            state <= ret;
          end
        end

        S_DIV: begin
          rem <= ge ? add_res[RW-1:0] : trial;
          dvd <= dvd << 1;
          q <= {q[QW-2:0], ge};
          ovf <= ovf | q[QW-1];
          cnt <= cnt - CNTW'(1);
          if (cnt == CNTW'(1)) begin
            state <= ret;
          end
        end

        // Numerator n*S: the sum of squares sits in acc after the scan.
        S_POST_NS: begin
          if (total == '0 || n_act == NBW'(1)) begin
            chi_res <= '0;
            state <= S_MEAN;
          end else begin
            mcand <= acc;
            acc <= '0;
            mplier <= MW'(n_act);
            mul_sub <= 1'b0;
            cnt <= CNTW'(NBW);
            ret <= S_POST_TT;
            state <= S_MUL;
          end
        end

        S_POST_TT: begin
          mcand <= AW'(total);
          mplier <= MW'(total);
          cnt <= CNTW'(TW);
          ret <= S_POST_TU;
          state <= S_MUL;
        end

        S_POST_TU: begin
          mcand <= AW'({uacc, 1'b0});
          mplier <= MW'(total);
          mul_sub <= 1'b1;
          cnt <= CNTW'(TW);
          ret <= S_POST_D;
          state <= S_MUL;
        end

        // Park the numerator in the dividend and form T*(n-1).
        S_POST_D: begin
          dvd <= {acc, {hbh_pkg::FRAC_W{1'b0}}};
          acc <= '0;
          mcand <= AW'(total);
          mplier <= MW'(n_minus1);
          mul_sub <= 1'b0;
          cnt <= CNTW'(NBW);
          ret <= S_POST_DIV;
          state <= S_MUL;
        end

        S_POST_DIV: begin
          dreg <= acc[RW-1:0];
          rem <= '0;
          q <= '0;
          ovf <= 1'b0;
          cnt <= CNTW'(DVW);
          ret <= S_POST_CHI;
          state <= S_DIV;
        end

        S_POST_CHI: begin
          if (ovf || q[QW-1:hbh_pkg::CHI_W] != '0) begin
            chi_res <= '1;
          end else begin
            chi_res <= q[hbh_pkg::CHI_W-1:0];
          end
          state <= S_MEAN;
        end

        S_MEAN: begin
          dvd <= {total, {hbh_pkg::FRAC_W{1'b0}}, {(DVW - hbh_pkg::MEAN_W){1'b0}}};
          dreg <= RW'(n_act);
          rem <= '0;
          q <= '0;
          ovf <= 1'b0;
          cnt <= CNTW'(hbh_pkg::MEAN_W);
          ret <= S_DONE;
          state <= S_DIV;
        end

        S_DONE: begin
          total_entries <= total;
          largest_bucket <= hbh_pkg::BUCKET_OUT_W'(peak);
          smallest_bucket <= hbh_pkg::BUCKET_OUT_W'(lo);
          empty_buckets <= hbh_pkg::EMPTY_W'(empty);
          mean_q16 <= q;
          chi_square_q16 <= chi_res;
          done <= 1'b1;
          state <= S_IDLE;
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hdl/hbh_ram.sv -----
`default_nettype none

// Single-port bucket memory with registered read (read before write).
module hbh_ram #(
  parameter int DEPTH = 65536,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ----- hdl/hbh_checker.sv -----
`default_nettype none

module hbh_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            start,
  input wire logic                            busy,
  input wire logic [hbh_pkg::CMD_W-1:0]       cmd,
  input wire logic                            done,
  input wire logic [hbh_pkg::BUCKET_OUT_W-1:0] largest_bucket,
  input wire logic [hbh_pkg::BUCKET_OUT_W-1:0] smallest_bucket
);

  // The memory sweep after reset keeps the block busy.
  a_reset_sweep: assert property (@(posedge clk) rst |=> busy)
    else $error("block not busy after reset");

  // A known command that is taken makes the block busy in the next cycle.
  a_cmd_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (cmd == hbh_pkg::CMD_ADD || cmd == hbh_pkg::CMD_CLEAR ||
     cmd == hbh_pkg::CMD_REPORT)) |=> busy)
    else $error("accepted command did not start work");

  // A result word lasts one cycle.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for more than one cycle");

  // The sequencer is idle when the result shows.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while busy");

  // The smallest bucket never exceeds the largest one.
  a_min_max: assert property (@(posedge clk) disable iff (rst)
    done |-> (smallest_bucket <= largest_bucket))
    else $error("smallest bucket above largest bucket");

endmodule

bind hash_bucket_histogram_stats_core hbh_checker u_hbh_checker (.*);

`default_nettype wire
